// ===== hdl/block_distributed_index_counter_core_defines.svh =====
// Assertion macros for the index counter core.
`ifndef BLOCK_DISTRIBUTED_INDEX_COUNTER_CORE_DEFINES_SVH
`define BLOCK_DISTRIBUTED_INDEX_COUNTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bdic_pkg.sv =====
package bdic_pkg;

    localparam int ID_W      = 40;
    localparam int SIZE_W    = 10;
    localparam int GRP_W     = 16;
    localparam int N_DIMS    = 4;
    localparam int DIDX_W    = 2;
    localparam int K_W       = 3;
    localparam int COORD_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int PC_W      = 5;

    localparam logic [1:0] ACT_SETUP = 2'd0;
    localparam logic [1:0] ACT_NEXT  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_ISSUED  = 2'd0;
    localparam logic [1:0] ST_NO_MORE = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PPU       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP     = 3'd6;

    typedef struct packed {
        logic [1:0]      action;
        logic            prev_valid;
        logic [ID_W-1:0] prev_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    linear_id;
        logic [COORD_W-1:0] coord0;
        logic [COORD_W-1:0] coord1;
        logic [COORD_W-1:0] coord2;
        logic [COORD_W-1:0] coord3;
        logic [ID_W-1:0]    range_start;
        logic [ID_W-1:0]    range_end;
        logic               range_empty;
    } t_out_item;

    typedef logic [PC_W-1:0] t_upc;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TOT_INIT,
        OP_TOT_MUL,
        OP_STR_INIT,
        OP_STR_WR,
        OP_STR_MUL,
        OP_RANGE_CLR,
        OP_DIV_PPU,
        OP_MUL_FIRST,
        OP_SET_LAST,
        OP_SINGLE,
        OP_RST,
        OP_NXT_INIT,
        OP_ID_SEL,
        OP_DIV_STR,
        OP_COORD_Q,
        OP_K_INC,
        OP_COORD_REM,
        OP_MOCK,
        OP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_K_EQ_D,
        C_K_EQ_1,
        C_D_ZERO,
        C_PPU_GT_TOT,
        C_GRP_GE_PPU,
        C_DIV_BUSY,
        C_NO_RANGE,
        C_PREV_END,
        C_K_EQ_DM1,
        C_STRIDE_Z
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  target;
        logic  last;
    } t_uword;

    typedef struct packed {
        logic k_eq_d;
        logic k_eq_1;
        logic d_zero;
        logic ppu_gt_tot;
        logic grp_ge_ppu;
        logic div_busy;
        logic no_range;
        logic prev_end;
        logic k_eq_dm1;
        logic stride_z;
        logic out_free;
    } t_flags;

    // Microprogram addresses
    localparam t_upc PC_SETUP     = 5'd0;
    localparam t_upc PC_TOT_CHK   = 5'd1;
    localparam t_upc PC_TOT_MUL   = 5'd2;
    localparam t_upc PC_STR_INIT  = 5'd3;
    localparam t_upc PC_STR_WR    = 5'd4;
    localparam t_upc PC_STR_MUL   = 5'd5;
    localparam t_upc PC_RNG_CLR   = 5'd6;
    localparam t_upc PC_GRP_CHK   = 5'd7;
    localparam t_upc PC_PPU_DIV   = 5'd8;
    localparam t_upc PC_PPU_WAIT  = 5'd9;
    localparam t_upc PC_FIRST     = 5'd10;
    localparam t_upc PC_LAST      = 5'd11;
    localparam t_upc PC_SINGLE    = 5'd12;
    localparam t_upc PC_RST       = 5'd13;
    localparam t_upc PC_NEXT      = 5'd14;
    localparam t_upc PC_RNG_CHK   = 5'd15;
    localparam t_upc PC_END_CHK   = 5'd16;
    localparam t_upc PC_ID_SEL    = 5'd17;
    localparam t_upc PC_SPLIT     = 5'd18;
    localparam t_upc PC_STR_CHK   = 5'd19;
    localparam t_upc PC_STR_DIV   = 5'd20;
    localparam t_upc PC_STR_WAIT  = 5'd21;
    localparam t_upc PC_COORD_Q   = 5'd22;
    localparam t_upc PC_K_INC     = 5'd23;
    localparam t_upc PC_COORD_REM = 5'd24;
    localparam t_upc PC_MOCK      = 5'd25;
    localparam t_upc PC_EMIT      = 5'd26;

    function automatic t_uword f_uw(t_uop op, t_cond cond, t_upc target, logic last);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    localparam t_uword UW_IDLE = '{op: OP_NOP, cond: C_NEVER, target: PC_SETUP, last: 1'b0};

    // Control store
    function automatic t_uword f_urom(t_upc pc);
        t_uword w;
        case (pc)
            PC_SETUP:     w = f_uw(OP_TOT_INIT,  C_NEVER,      PC_SETUP,     1'b0);
            PC_TOT_CHK:   w = f_uw(OP_NOP,       C_K_EQ_D,     PC_STR_INIT,  1'b0);
            PC_TOT_MUL:   w = f_uw(OP_TOT_MUL,   C_ALWAYS,     PC_TOT_CHK,   1'b0);
            PC_STR_INIT:  w = f_uw(OP_STR_INIT,  C_D_ZERO,     PC_RNG_CLR,   1'b0);
            PC_STR_WR:    w = f_uw(OP_STR_WR,    C_K_EQ_1,     PC_RNG_CLR,   1'b0);
            PC_STR_MUL:   w = f_uw(OP_STR_MUL,   C_ALWAYS,     PC_STR_WR,    1'b0);
            PC_RNG_CLR:   w = f_uw(OP_RANGE_CLR, C_PPU_GT_TOT, PC_SINGLE,    1'b0);
            PC_GRP_CHK:   w = f_uw(OP_NOP,       C_GRP_GE_PPU, PC_EMIT,      1'b0);
            PC_PPU_DIV:   w = f_uw(OP_DIV_PPU,   C_NEVER,      PC_SETUP,     1'b0);
            PC_PPU_WAIT:  w = f_uw(OP_NOP,       C_DIV_BUSY,   PC_PPU_WAIT,  1'b0);
            PC_FIRST:     w = f_uw(OP_MUL_FIRST, C_NEVER,      PC_SETUP,     1'b0);
            PC_LAST:      w = f_uw(OP_SET_LAST,  C_ALWAYS,     PC_EMIT,      1'b0);
            PC_SINGLE:    w = f_uw(OP_SINGLE,    C_ALWAYS,     PC_EMIT,      1'b0);
            PC_RST:       w = f_uw(OP_RST,       C_ALWAYS,     PC_EMIT,      1'b0);
            PC_NEXT:      w = f_uw(OP_NXT_INIT,  C_D_ZERO,     PC_MOCK,      1'b0);
            PC_RNG_CHK:   w = f_uw(OP_NOP,       C_NO_RANGE,   PC_EMIT,      1'b0);
            PC_END_CHK:   w = f_uw(OP_NOP,       C_PREV_END,   PC_EMIT,      1'b0);
            PC_ID_SEL:    w = f_uw(OP_ID_SEL,    C_NEVER,      PC_SETUP,     1'b0);
            PC_SPLIT:     w = f_uw(OP_NOP,       C_K_EQ_DM1,   PC_COORD_REM, 1'b0);
            PC_STR_CHK:   w = f_uw(OP_NOP,       C_STRIDE_Z,   PC_K_INC,     1'b0);
            PC_STR_DIV:   w = f_uw(OP_DIV_STR,   C_NEVER,      PC_SETUP,     1'b0);
            PC_STR_WAIT:  w = f_uw(OP_NOP,       C_DIV_BUSY,   PC_STR_WAIT,  1'b0);
            PC_COORD_Q:   w = f_uw(OP_COORD_Q,   C_ALWAYS,     PC_SPLIT,     1'b0);
            PC_K_INC:     w = f_uw(OP_K_INC,     C_ALWAYS,     PC_SPLIT,     1'b0);
            PC_COORD_REM: w = f_uw(OP_COORD_REM, C_ALWAYS,     PC_EMIT,      1'b0);
            PC_MOCK:      w = f_uw(OP_MOCK,      C_ALWAYS,     PC_EMIT,      1'b0);
            PC_EMIT:      w = f_uw(OP_EMIT,      C_NEVER,      PC_EMIT,      1'b1);
            default:      w = UW_IDLE;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/bdic_div.sv =====
module bdic_div import bdic_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [ID_W-1:0] i_dividend,
    input  logic [ID_W-1:0] i_divisor,
    output logic            o_busy,
    output logic [ID_W-1:0] o_quot,
    output logic [ID_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(ID_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [ID_W-1:0]  r_quo;
    logic [ID_W-1:0]  r_rem;
    logic [ID_W-1:0]  r_dvs;
    logic [ID_W:0]    rem_sh;
    logic [ID_W:0]    diff;

    // One quotient bit per cycle, restoring form
    assign rem_sh = {r_rem, r_quo[ID_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ID_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[ID_W]) begin
                r_rem <= diff[ID_W-1:0];
                r_quo <= {r_quo[ID_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[ID_W-1:0];
                r_quo <= {r_quo[ID_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/bdic_seq.sv =====
module bdic_seq import bdic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_flags     i_flags,
    output t_uword     o_uw,
    output logic       o_busy
);

    logic   r_busy;
    t_upc   r_pc;
    logic   n_busy;
    t_upc   n_pc;
    t_uword uw;
    logic   taken;

    assign uw = f_urom(r_pc);

    always_comb begin
        case (uw.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_K_EQ_D:     taken = i_flags.k_eq_d;
            C_K_EQ_1:     taken = i_flags.k_eq_1;
            C_D_ZERO:     taken = i_flags.d_zero;
            C_PPU_GT_TOT: taken = i_flags.ppu_gt_tot;
            C_GRP_GE_PPU: taken = i_flags.grp_ge_ppu;
            C_DIV_BUSY:   taken = i_flags.div_busy;
            C_NO_RANGE:   taken = i_flags.no_range;
            C_PREV_END:   taken = i_flags.prev_end;
            C_K_EQ_DM1:   taken = i_flags.k_eq_dm1;
            C_STRIDE_Z:   taken = i_flags.stride_z;
            default:      taken = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                case (i_action)
                    ACT_SETUP: begin
                        n_busy = 1'b1;
                        n_pc   = PC_SETUP;
                    end
                    ACT_NEXT: begin
                        n_busy = 1'b1;
                        n_pc   = PC_NEXT;
                    end
                    ACT_RESET: begin
                        n_busy = 1'b1;
                        n_pc   = PC_RST;
                    end
                    default: begin
                        n_busy = 1'b0;
                    end
                endcase
            end
        end else if (uw.last) begin
            // hold on the final step until the result register frees up
            if (i_flags.out_free) begin
                n_busy = 1'b0;
            end
        end else if (taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_SETUP;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    // Outputs
    always_comb begin
        o_uw   = r_busy ? uw : UW_IDLE;
        o_busy = r_busy;
    end

endmodule

// ===== hdl/bdic_dp.sv =====
module bdic_dp import bdic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  t_in_item             i_item,
    input  t_uword               i_uw,
    input  logic                 i_out_stall,
    output t_flags               o_flags,
    output logic                 o_out_valid,
    output t_out_item            o_out_data
);

    localparam int PROD_W = ID_W + GRP_W;

    // configuration
    logic [K_W-1:0]    r_dim_cnt;
    logic [SIZE_W-1:0] r_size [N_DIMS];
    logic [GRP_W-1:0]  r_ppu;
    logic [GRP_W-1:0]  r_grp;

    // range and result control
    logic              r_rng_valid;
    logic [ID_W-1:0]   r_first;
    logic [ID_W-1:0]   r_last;
    logic              r_out_valid;
    t_out_item         r_out;

    // working registers
    logic [ID_W-1:0]    r_tot;
    logic [ID_W-1:0]    r_acc;
    logic [K_W-1:0]     r_k;
    logic [ID_W-1:0]    r_rem;
    logic [ID_W-1:0]    r_id;
    logic [1:0]         r_status;
    logic               r_prev_valid;
    logic [ID_W-1:0]    r_prev_id;
    logic [ID_W-1:0]    r_stride [N_DIMS];
    logic [COORD_W-1:0] r_coord [N_DIMS];

    logic [K_W-1:0]    dims;
    logic [K_W-1:0]    dims_m1;
    logic [K_W-1:0]    k_m1;
    logic [DIDX_W-1:0] kidx;
    logic [DIDX_W-1:0] sidx;
    logic [GRP_W-1:0]  ppu_eff;
    logic [ID_W-1:0]   mul_a;
    logic [GRP_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [ID_W-1:0]   prod_sat;
    logic              div_start;
    logic [ID_W-1:0]   div_dividend;
    logic [ID_W-1:0]   div_divisor;
    logic              div_busy;
    logic [ID_W-1:0]   div_quot;
    logic [ID_W-1:0]   div_rem;
    logic [ID_W-1:0]   extra;
    logic              issued;
    logic              out_free;
    logic              emit;

    assign dims     = (r_dim_cnt > K_W'(N_DIMS)) ? K_W'(N_DIMS) : r_dim_cnt;
    assign dims_m1  = dims - 1'b1;
    assign k_m1     = r_k - 1'b1;
    assign kidx     = r_k[DIDX_W-1:0];
    assign sidx     = (i_uw.op == OP_STR_MUL) ? k_m1[DIDX_W-1:0] : kidx;
    assign ppu_eff  = (r_ppu == '0) ? GRP_W'(1) : r_ppu;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (i_uw.op == OP_EMIT) && out_free;

    // shared multiplier; totals and strides saturate at the largest id
    always_comb begin
        case (i_uw.op)
            OP_TOT_MUL: begin
                mul_a = r_tot;
                mul_b = GRP_W'(r_size[sidx]);
            end
            OP_STR_MUL: begin
                mul_a = r_acc;
                mul_b = GRP_W'(r_size[sidx]);
            end
            default: begin
                mul_a = div_quot;
                mul_b = r_grp;
            end
        endcase
    end

    assign prod     = {{GRP_W{1'b0}}, mul_a} * {{ID_W{1'b0}}, mul_b};
    assign prod_sat = (|prod[PROD_W-1:ID_W]) ? {ID_W{1'b1}} : prod[ID_W-1:0];

    assign div_start    = (i_uw.op == OP_DIV_PPU) || (i_uw.op == OP_DIV_STR);
    assign div_dividend = (i_uw.op == OP_DIV_PPU) ? r_tot : r_rem;
    assign div_divisor  = (i_uw.op == OP_DIV_PPU) ? ID_W'(ppu_eff) : r_stride[kidx];

    bdic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // the last group also takes the remainder
    assign extra = (r_grp == ppu_eff - 1'b1) ? div_rem : '0;

    always_comb begin
        o_flags.k_eq_d     = (r_k == dims);
        o_flags.k_eq_1     = (r_k == K_W'(1));
        o_flags.d_zero     = (dims == '0);
        o_flags.ppu_gt_tot = (ID_W'(ppu_eff) > r_tot);
        o_flags.grp_ge_ppu = (r_grp >= ppu_eff);
        o_flags.div_busy   = div_busy;
        o_flags.no_range   = !r_rng_valid;
        o_flags.prev_end   = r_prev_valid && (r_prev_id >= r_last);
        o_flags.k_eq_dm1   = (r_k == dims_m1);
        o_flags.stride_z   = (r_stride[kidx] == '0);
        o_flags.out_free   = out_free;
    end

    // configuration, range and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_cnt   <= K_W'(1);
            for (int i = 0; i < N_DIMS; i++) begin
                r_size[i] <= SIZE_W'(1);
            end
            r_ppu       <= GRP_W'(1);
            r_grp       <= '0;
            r_rng_valid <= 1'b0;
            r_first     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIM_COUNT: r_dim_cnt <= i_cfg_data[K_W-1:0];
                    CFG_SIZE0:     r_size[0] <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE1:     r_size[1] <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE2:     r_size[2] <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE3:     r_size[3] <= i_cfg_data[SIZE_W-1:0];
                    CFG_PPU:       r_ppu     <= i_cfg_data[GRP_W-1:0];
                    CFG_GROUP:     r_grp     <= i_cfg_data[GRP_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_uw.op)
                OP_RANGE_CLR, OP_RST: begin
                    r_rng_valid <= 1'b0;
                    r_first     <= '0;
                    r_last      <= '0;
                end
                OP_MUL_FIRST: begin
                    r_first <= prod[ID_W-1:0];
                end
                OP_SET_LAST: begin
                    r_rng_valid <= 1'b1;
                    r_last      <= r_first + div_quot - 1'b1 + extra;
                end
                OP_SINGLE: begin
                    if (ID_W'(r_grp) < r_tot) begin
                        r_rng_valid <= 1'b1;
                        r_first     <= ID_W'(r_grp);
                        r_last      <= ID_W'(r_grp);
                    end
                end
                default: begin
                end
            endcase
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign issued = (r_status == ST_ISSUED);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prev_valid <= i_item.prev_valid;
            r_prev_id    <= i_item.prev_id;
        end
        case (i_uw.op)
            OP_TOT_INIT: begin
                r_tot    <= ID_W'(1);
                r_k      <= '0;
                r_status <= ST_DONE;
            end
            OP_TOT_MUL: begin
                r_tot <= prod_sat;
                r_k   <= r_k + 1'b1;
            end
            OP_STR_INIT: begin
                r_acc <= ID_W'(1);
                r_k   <= dims;
            end
            OP_STR_WR: begin
                r_stride[k_m1[DIDX_W-1:0]] <= r_acc;
            end
            OP_STR_MUL: begin
                r_acc <= prod_sat;
                r_k   <= k_m1;
            end
            OP_RST: begin
                r_status <= ST_DONE;
            end
            OP_NXT_INIT: begin
                r_status <= ST_NO_MORE;
                r_id     <= '0;
                r_k      <= '0;
                for (int i = 0; i < N_DIMS; i++) begin
                    r_coord[i] <= '0;
                end
            end
            OP_ID_SEL: begin
                r_status <= ST_ISSUED;
                if (r_prev_valid) begin
                    r_id  <= r_prev_id + 1'b1;
                    r_rem <= r_prev_id + 1'b1;
                end else begin
                    r_id  <= r_first;
                    r_rem <= r_first;
                end
            end
            OP_COORD_Q: begin
                r_coord[kidx] <= div_quot[COORD_W-1:0];
                r_rem         <= div_rem;
                r_k           <= r_k + 1'b1;
            end
            OP_K_INC: begin
                r_k <= r_k + 1'b1;
            end
            OP_COORD_REM: begin
                r_coord[kidx] <= r_rem[COORD_W-1:0];
            end
            OP_MOCK: begin
                if (r_grp == '0 && !r_prev_valid) begin
                    r_status <= ST_ISSUED;
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_out.status      <= r_status;
            r_out.linear_id   <= issued ? r_id : '0;
            r_out.coord0      <= issued ? r_coord[0] : '0;
            r_out.coord1      <= issued ? r_coord[1] : '0;
            r_out.coord2      <= issued ? r_coord[2] : '0;
            r_out.coord3      <= issued ? r_coord[3] : '0;
            r_out.range_start <= r_first;
            r_out.range_end   <= r_last;
            r_out.range_empty <= !r_rng_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/block_distributed_index_counter_core.sv =====
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall    o_out_data (t_out_item)
// cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One transaction at a time, run by a microprogram over a shared 40-bit
// restoring divider (one quotient bit a cycle). A setup divides the total once when
// it is split over the groups; a next id divides once per non-zero stride split,
// up to three of them. Synchronous active-low reset clears configuration to defaults
// and the range. The input stalls during reset and while a transaction is in flight;
// a finished result waits in the output register, and the next transaction is taken
// meanwhile.
`include "block_distributed_index_counter_core_defines.svh"

module block_distributed_index_counter_core import bdic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic   busy;
    logic   accept;
    t_uword uw;
    t_flags flags;

    assign o_in_stall = busy || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;

    bdic_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_action (i_in_data.action),
        .i_flags  (flags),
        .o_uw     (uw),
        .o_busy   (busy)
    );

    bdic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .i_uw        (uw),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `BDIC_ASSERT_NEXT(a_start_busy, i_in_valid && !o_in_stall && i_in_data.action != ACT_NONE, o_in_stall, "valid transaction did not start the sequencer")
    `BDIC_ASSERT_NOW(a_id_zero, o_out_valid && o_out_data.status != ST_ISSUED, o_out_data.linear_id == '0, "non-zero id on a result without an issued id")
    `BDIC_ASSERT_NOW(a_empty_range, o_out_valid && o_out_data.range_empty, o_out_data.range_start == '0 && o_out_data.range_end == '0, "empty range reported with non-zero bounds")

endmodule

// ===== dv/tb_block_distributed_index_counter_core.sv =====
module tb_block_distributed_index_counter_core;
    import bdic_pkg::*;

    localparam int ITEM_TARGET   = 950;
    localparam int SETTLE_CYCLES = 160;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_LIMIT     = 20_000_000;

    localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

    typedef enum logic {STEP_WRITE, STEP_ITEM} t_step_kind;

    typedef struct {
        t_step_kind          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]    value;
        t_in_item            req;
        bit                  typed;
        t_out_item           reply;
    } t_step;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_item             in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;

    // Register image and counter state
    logic [2:0]        dim_reg;
    logic [SIZE_W-1:0] size_reg [N_DIMS];
    logic [GRP_W-1:0]  ppu_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [ID_W-1:0]   rng_first;
    logic [ID_W-1:0]   rng_last;
    bit                rng_held;
    logic [ID_W-1:0]   stride_tab [N_DIMS];

    t_out_item pending_replies[$];
    t_step     plan[$];
    int        mismatches = 0;
    int        n_sent = 0;
    bit        burst = 1'b0;
    bit        hold_out = 1'b0;
    t_out_item last_reply;
    bit        last_has;
    logic [ID_W-1:0] walk_id = '0;
    bit        walk_live = 1'b0;

    block_distributed_index_counter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ID_W-1:0] mul_sat(input logic [ID_W-1:0] a,
                                                input logic [ID_W-1:0] b);
        logic [2*ID_W-1:0] p;
        p = a * b;
        return (p > (2*ID_W)'(ID_ALL_ONES)) ? ID_ALL_ONES : p[ID_W-1:0];
    endfunction

    function automatic void clear_counter();
        dim_reg = 3'd1;
        for (int i = 0; i < N_DIMS; i++) begin
            size_reg[i]   = 10'd1;
            stride_tab[i] = '0;
        end
        ppu_reg   = 16'd1;
        grp_reg   = '0;
        rng_first = '0;
        rng_last  = '0;
        rng_held  = 1'b0;
    endfunction

    // Work out the reply of one transaction and advance the counter state.
    function automatic bit compute_reply(input t_in_item req, output t_out_item reply);
        int              d;
        logic [ID_W-1:0] total, s, ppu_eff, per, extra, id, rem, q;
        logic [COORD_W-1:0] coord [N_DIMS];
        bit              issue;
        reply = '0;
        for (int i = 0; i < N_DIMS; i++) coord[i] = '0;
        if (req.action == ACT_NONE) return 1'b0;
        d = (dim_reg > 3'd4) ? N_DIMS : int'(dim_reg);
        id = '0;
        issue = 1'b0;
        reply.status = ST_NO_MORE;
        if (req.action == ACT_SETUP) begin
            total = 1;
            for (int i = 0; i < d; i++) total = mul_sat(total, ID_W'(size_reg[i]));
            if (d > 0) begin
                s = 1;
                stride_tab[d-1] = 1;
                for (int i = d - 1; i > 0; i--) begin
                    s = mul_sat(s, ID_W'(size_reg[i]));
                    stride_tab[i-1] = s;
                end
            end
            ppu_eff = (ppu_reg == 0) ? ID_W'(1) : ID_W'(ppu_reg);
            rng_held  = 1'b0;
            rng_first = '0;
            rng_last  = '0;
            if (ppu_eff > total) begin
                if (ID_W'(grp_reg) < total) begin
                    rng_held  = 1'b1;
                    rng_first = ID_W'(grp_reg);
                    rng_last  = ID_W'(grp_reg);
                end
            end else if (ID_W'(grp_reg) < ppu_eff) begin
                per   = total / ppu_eff;
                extra = total % ppu_eff;
                rng_held  = 1'b1;
                rng_first = per * ID_W'(grp_reg);
                rng_last  = rng_first + per - 1;
                // last group soaks up the remainder
                if (ID_W'(grp_reg) == ppu_eff - 1) rng_last = rng_last + extra;
            end
            reply.status = ST_DONE;
        end else if (req.action == ACT_RESET) begin
            rng_held  = 1'b0;
            rng_first = '0;
            rng_last  = '0;
            reply.status = ST_DONE;
        end else if (d == 0) begin
            issue = (grp_reg == 0) && !req.prev_valid;
        end else if (rng_held) begin
            if (!req.prev_valid) begin
                id = rng_first;
                issue = 1'b1;
            end else if (req.prev_id < rng_last) begin
                id = req.prev_id + 1;
                issue = 1'b1;
            end
            if (issue) begin
                // split with whatever strides the last setup left behind
                rem = id;
                for (int i = 0; i + 1 < d; i++) begin
                    s = stride_tab[i];
                    q = '0;
                    if (s != 0) begin
                        q   = rem / s;
                        rem = rem % s;
                    end
                    coord[i] = q[COORD_W-1:0];
                end
                coord[d-1] = rem[COORD_W-1:0];
            end
        end
        if (issue) begin
            reply.status    = ST_ISSUED;
            reply.linear_id = id;
        end
        reply.coord0      = coord[0];
        reply.coord1      = coord[1];
        reply.coord2      = coord[2];
        reply.coord3      = coord[3];
        reply.range_start = rng_first;
        reply.range_end   = rng_last;
        reply.range_empty = !rng_held;
        return 1'b1;
    endfunction

    function automatic t_out_item mk_reply(input logic [1:0] st, input logic [ID_W-1:0] id,
                                           input logic [COORD_W-1:0] c0, c1,
                                           input logic [ID_W-1:0] rs, re, input logic emp);
        t_out_item r;
        r = '0;
        r.status      = st;
        r.linear_id   = id;
        r.coord0      = c0;
        r.coord1      = c1;
        r.range_start = rs;
        r.range_end   = re;
        r.range_empty = emp;
        return r;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
        t_step st;
        st = '{kind: STEP_WRITE, idx: idx, value: value, req: '0, typed: 1'b0, reply: '0};
        plan.push_back(st);
    endfunction

    function automatic void add_item(input logic [1:0] act, input logic pv,
                                     input logic [ID_W-1:0] prev);
        t_step st;
        st = '{kind: STEP_ITEM, idx: '0, value: '0, req: '{act, pv, prev},
               typed: 1'b0, reply: '0};
        plan.push_back(st);
    endfunction

    function automatic void add_checked(input logic [1:0] act, input logic pv,
                                        input logic [ID_W-1:0] prev, input t_out_item r);
        t_step st;
        st = '{kind: STEP_ITEM, idx: '0, value: '0, req: '{act, pv, prev},
               typed: 1'b1, reply: r};
        plan.push_back(st);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return {8'($urandom()), 32'($urandom())};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return '0;
        if (r < 12) return 16'd1023;
        if (r < 22) return 16'($urandom_range(1, 1023));
        return 16'($urandom_range(1, 6));
    endfunction

    // Mostly walk the range forward from the last issued id; the rest is noise.
    function automatic t_in_item next_request();
        t_in_item req;
        int r;
        req.action     = ACT_NEXT;
        req.prev_valid = 1'b1;
        req.prev_id    = rand_id();
        r = $urandom_range(0, 99);
        if (r < 60) begin
            req.prev_valid = walk_live;
            if (walk_live) req.prev_id = walk_id;
        end else if (r < 66) begin
            req.prev_valid = 1'b0;
        end else if (r < 72) begin
            // keep the random previous id
        end else if (r < 77) begin
            req.prev_id = rng_last - ID_W'($urandom_range(0, 2));
        end else if (r < 81) begin
            req.prev_id = rng_first - ID_W'($urandom_range(1, 3));
        end else if (r < 86) begin
            req.action = ACT_SETUP;
        end else if (r < 90) begin
            req.action = ACT_RESET;
        end else if (r < 94) begin
            req.action = ACT_NONE;
            req.prev_valid = 1'($urandom());
        end else begin
            req.prev_id = walk_id;
        end
        return req;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_DIM_COUNT: dim_reg = value[2:0];
            CFG_SIZE0:     size_reg[0] = value[SIZE_W-1:0];
            CFG_SIZE1:     size_reg[1] = value[SIZE_W-1:0];
            CFG_SIZE2:     size_reg[2] = value[SIZE_W-1:0];
            CFG_SIZE3:     size_reg[3] = value[SIZE_W-1:0];
            CFG_PPU:       ppu_reg = value;
            CFG_GROUP:     grp_reg = value;
            default:       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, let every reply drain and give any ignored transaction time to finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic offer_request(input t_in_item req, input bit typed,
                                 input t_out_item typed_reply);
        t_out_item reply;
        bit        has_reply;
        int        gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        has_reply = compute_reply(req, reply);
        if (has_reply) pending_replies.push_back(typed ? typed_reply : reply);
        last_reply = reply;
        last_has   = has_reply;
        if (req.action != ACT_NONE) n_sent++;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : check_replies
        t_out_item want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transaction, expected none got %p", $time, o_out_data);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                compare_field("status", ID_W'(want.status), ID_W'(o_out_data.status));
                compare_field("linear_id", want.linear_id, o_out_data.linear_id);
                compare_field("coord0", ID_W'(want.coord0), ID_W'(o_out_data.coord0));
                compare_field("coord1", ID_W'(want.coord1), ID_W'(o_out_data.coord1));
                compare_field("coord2", ID_W'(want.coord2), ID_W'(o_out_data.coord2));
                compare_field("coord3", ID_W'(want.coord3), ID_W'(o_out_data.coord3));
                compare_field("range_start", want.range_start, o_out_data.range_start);
                compare_field("range_end", want.range_end, o_out_data.range_end);
                compare_field("range_empty", ID_W'(want.range_empty),
                              ID_W'(o_out_data.range_empty));
            end
        end
    end

    // Receiver: random stall stretches, plus one long hold-off on request.
    initial begin : out_side
        int r;
        int span;
        forever begin
            @(negedge clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    out_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else if (r < 30) begin
                    out_stall <= 1'b1;
                    span = $urandom_range(10, 40);
                end else begin
                    out_stall <= 1'b0;
                    span = $urandom_range(1, 20);
                end
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        bit       cfg_open;
        bit       hold_done;
        int       len;
        int       pick;
        logic [ID_W-1:0] ppu_eff;
        t_in_item req;

        cfg_open  = 1'b0;
        hold_done = 1'b0;
        clear_counter();

        // default configuration: one dimension of one unit, one group
        add_checked(ACT_NEXT,  1'b0, '0, mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b1));
        add_item   (ACT_NONE,  1'b1, ID_ALL_ONES);
        add_checked(ACT_SETUP, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_NEXT,  1'b0, '0, mk_reply(ST_ISSUED, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_NEXT,  1'b1, '0, mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_NEXT,  1'b1, ID_ALL_ONES,
                    mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_RESET, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b1));
        // oversized dim count, largest sizes and group count; writes every stride
        add_write(CFG_DIM_COUNT, 16'd7);
        add_write(CFG_SIZE0, 16'd1023);
        add_write(CFG_SIZE1, 16'd1023);
        add_write(CFG_SIZE2, 16'd1023);
        add_write(CFG_SIZE3, 16'd1023);
        add_write(CFG_PPU, 16'hFFFF);
        add_write(CFG_GROUP, 16'd3);
        add_item(ACT_SETUP, 1'b0, '0);
        add_item(ACT_NEXT,  1'b0, '0);
        add_item(ACT_NEXT,  1'b1, '0);
        add_item(ACT_NEXT,  1'b1, ID_ALL_ONES);
        // group index not below group count
        add_write(CFG_GROUP, 16'hFFFF);
        add_checked(ACT_SETUP, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b1));
        add_checked(ACT_NEXT,  1'b0, '0, mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b1));
        // zero group count, two dimensions; last id gives the largest coordinates
        add_write(CFG_PPU, 16'd0);
        add_write(CFG_GROUP, 16'd0);
        add_write(CFG_DIM_COUNT, 16'd2);
        add_item(ACT_SETUP, 1'b0, '0);
        add_checked(ACT_NEXT, 1'b1, 40'd1046527,
                    mk_reply(ST_ISSUED, 40'd1046528, 10'd1022, 10'd1022, '0, 40'd1046528, 1'b0));
        // stale strides after a dim count change
        add_write(CFG_DIM_COUNT, 16'd4);
        add_item(ACT_NEXT, 1'b1, 40'd1046000);
        // zero size leaves zero strides behind for a later stale split
        add_write(CFG_SIZE3, 16'd0);
        add_checked(ACT_SETUP, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b1));
        add_write(CFG_DIM_COUNT, 16'd1);
        add_item(ACT_SETUP, 1'b0, '0);
        add_write(CFG_DIM_COUNT, 16'd4);
        add_item(ACT_NEXT, 1'b1, 40'd700);
        // mock mode
        add_write(CFG_DIM_COUNT, 16'd0);
        add_write(CFG_PPU, 16'd1000);
        add_write(CFG_SIZE3, 16'd1023);
        add_checked(ACT_SETUP, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_NEXT,  1'b0, '0, mk_reply(ST_ISSUED, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_NEXT,  1'b1, 40'd5, mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b0));
        add_write(CFG_GROUP, 16'd1);
        add_checked(ACT_NEXT,  1'b0, '0, mk_reply(ST_NO_MORE, '0, '0, '0, '0, '0, 1'b0));
        add_checked(ACT_RESET, 1'b0, '0, mk_reply(ST_DONE, '0, '0, '0, '0, '0, 1'b1));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k]) begin
            if (plan[k].kind == STEP_WRITE) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_reg(plan[k].idx, plan[k].value);
            end else begin
                cfg_open = 1'b0;
                offer_request(plan[k].req, plan[k].typed, plan[k].reply);
            end
        end

        while (n_sent < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      write_reg(CFG_DIM_COUNT, 16'd0);
                else if (pick < 20) write_reg(CFG_DIM_COUNT, 16'($urandom_range(5, 7)));
                else                write_reg(CFG_DIM_COUNT, 16'($urandom_range(1, 4)));
            end
            if ($urandom_range(0, 1)) write_reg(CFG_SIZE0, rand_size());
            if ($urandom_range(0, 1)) write_reg(CFG_SIZE1, rand_size());
            if ($urandom_range(0, 1)) write_reg(CFG_SIZE2, rand_size());
            if ($urandom_range(0, 1)) write_reg(CFG_SIZE3, rand_size());
            if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)       write_reg(CFG_PPU, 16'd0);
                else if (pick < 10) write_reg(CFG_PPU, 16'hFFFF);
                else if (pick < 25) write_reg(CFG_PPU, 16'($urandom()));
                else                write_reg(CFG_PPU, 16'($urandom_range(1, 6)));
            end
            if ($urandom_range(0, 1)) begin
                ppu_eff = (ppu_reg == 0) ? ID_W'(1) : ID_W'(ppu_reg);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    write_reg(CFG_GROUP, 16'($urandom_range(0, int'(ppu_eff) - 1)));
                else if (pick < 80)
                    write_reg(CFG_GROUP, 16'(ppu_eff - 1));
                else if (pick < 90 && ppu_eff < 40'hFFFF)
                    write_reg(CFG_GROUP, 16'($urandom_range(int'(ppu_eff), 65535)));
                else
                    write_reg(CFG_GROUP, 16'($urandom()));
            end
            burst = ($urandom_range(0, 5) == 0);
            if (!hold_done && n_sent > 300) begin
                // hold the output long enough for the block to back up into its input
                burst     = 1'b1;
                hold_out  = 1'b1;
                hold_done = 1'b1;
            end
            walk_live = 1'b0;
            if ($urandom_range(0, 99) < 85)
                offer_request('{ACT_SETUP, 1'($urandom()), rand_id()}, 1'b0, '0);
            len = $urandom_range(10, 40);
            repeat (len) begin
                req = next_request();
                offer_request(req, 1'b0, '0);
                if (req.action == ACT_NEXT && last_has && last_reply.status == ST_ISSUED) begin
                    walk_id   = last_reply.linear_id;
                    walk_live = 1'b1;
                end else if (req.action != ACT_NONE) begin
                    walk_live = 1'b0;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
